FILE: rtl/core/fete_pkg.sv
// ----------------------------------------------------------------------------
// fete_pkg
// Shared types and constants of the escape-time fractal engine.
// ----------------------------------------------------------------------------
package fete_pkg;

  localparam int COORD_BITS   = 12;
  localparam int FRAC_BITS    = 28;
  localparam int WORD_BITS    = 32;
  localparam int ITER_BITS    = 16;
  localparam int PIX_BITS     = 12;
  localparam int MODE_BITS    = 2;
  localparam int REG_IDX_BITS = 3;

  // coordinate bits that take part in the mapping
  localparam int PIX_USE = (COORD_BITS < PIX_BITS) ? COORD_BITS : PIX_BITS;

  localparam logic [MODE_BITS-1:0] MODE_MANDEL = MODE_BITS'(0);
  localparam logic [MODE_BITS-1:0] MODE_SHIP   = MODE_BITS'(1);
  localparam logic [MODE_BITS-1:0] MODE_JULIA  = MODE_BITS'(2);

  localparam logic [REG_IDX_BITS-1:0] REG_MODE     = REG_IDX_BITS'(0);
  localparam logic [REG_IDX_BITS-1:0] REG_MAX_ITER = REG_IDX_BITS'(1);
  localparam logic [REG_IDX_BITS-1:0] REG_X_ORIGIN = REG_IDX_BITS'(2);
  localparam logic [REG_IDX_BITS-1:0] REG_X_STEP   = REG_IDX_BITS'(3);
  localparam logic [REG_IDX_BITS-1:0] REG_Y_ORIGIN = REG_IDX_BITS'(4);
  localparam logic [REG_IDX_BITS-1:0] REG_Y_STEP   = REG_IDX_BITS'(5);
  localparam logic [REG_IDX_BITS-1:0] REG_JC_RE    = REG_IDX_BITS'(6);
  localparam logic [REG_IDX_BITS-1:0] REG_JC_IM    = REG_IDX_BITS'(7);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_LOAD,
    ST_SQUARE,
    ST_STEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic [ITER_BITS-1:0] max_iter;
    logic [WORD_BITS-1:0] x_origin;
    logic [WORD_BITS-1:0] x_step;
    logic [WORD_BITS-1:0] y_origin;
    logic [WORD_BITS-1:0] y_step;
    logic [WORD_BITS-1:0] jc_re;
    logic [WORD_BITS-1:0] jc_im;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic map;
    logic load;
    logic square;
    logic advance;
    logic count;
  } cmd_t;

  typedef struct packed {
    logic julia;
    logic mag_below;
    logic mag_above;
    logic at_max;
    logic next_at_max;
  } stat_t;

endpackage

FILE: rtl/core/fete_regs.sv
// ----------------------------------------------------------------------------
// fete_regs
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module fete_regs import fete_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [REG_IDX_BITS-1:0] wr_index,
  input  logic [WORD_BITS-1:0]    wr_data,
  output cfg_t                    cfg
);

  localparam cfg_t CFG_RESET = '{
    mode:     MODE_MANDEL,
    max_iter: ITER_BITS'(64),
    x_origin: 32'hE000_0000,
    x_step:   32'h0004_0000,
    y_origin: 32'hE800_0000,
    y_step:   32'h0004_0000,
    jc_re:    32'h0000_0000,
    jc_im:    32'h0000_0000
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MODE:     cfg.mode     <= wr_data[MODE_BITS-1:0];
        REG_MAX_ITER: cfg.max_iter <= wr_data[ITER_BITS-1:0];
        REG_X_ORIGIN: cfg.x_origin <= wr_data;
        REG_X_STEP:   cfg.x_step   <= wr_data;
        REG_Y_ORIGIN: cfg.y_origin <= wr_data;
        REG_Y_STEP:   cfg.y_step   <= wr_data;
        REG_JC_RE:    cfg.jc_re    <= wr_data;
        REG_JC_IM:    cfg.jc_im    <= wr_data;
        default:      cfg          <= cfg;
      endcase
    end
  end

endmodule

FILE: rtl/core/fete_dp.sv
// ----------------------------------------------------------------------------
// fete_dp
// Datapath: pixel mapping, complex squaring, magnitude test and counter.
// ----------------------------------------------------------------------------
module fete_dp import fete_pkg::*; (
  input  logic                 clk,
  input  cfg_t                 cfg,
  input  cmd_t                 cmd,
  input  logic [PIX_BITS-1:0]  pixel_col,
  input  logic [PIX_BITS-1:0]  pixel_row,
  output stat_t                stat,
  output logic [ITER_BITS-1:0] iter_count,
  output logic [PIX_BITS-1:0]  out_col,
  output logic [PIX_BITS-1:0]  out_row
);

  localparam int PROD_BITS = PIX_BITS + 1 + WORD_BITS;
  localparam int SQ_BITS   = 2 * WORD_BITS;
  localparam int SUM_BITS  = SQ_BITS + 1;
  localparam int MAG_EXP   = 2 + 2 * FRAC_BITS;
  localparam bit MAG_REACH = (MAG_EXP < SQ_BITS);

  localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic signed [SUM_BITS-1:0]  SUM_MAX  = WORD_MAX;
  localparam logic signed [SUM_BITS-1:0]  SUM_MIN  = WORD_MIN;
  localparam logic [SQ_BITS-1:0] MAG_LIMIT = MAG_REACH ? (SQ_BITS'(1) << MAG_EXP) : '0;
  // min^2 - max^2 of a word, restores the square of a clipped absolute value
  localparam logic [SQ_BITS-1:0] MIN_FIX = (SQ_BITS'(1) << WORD_BITS) - SQ_BITS'(1);

  function automatic logic signed [WORD_BITS-1:0] sat_word(
    input logic signed [SUM_BITS-1:0] v
  );
    logic signed [WORD_BITS-1:0] r;
    if (v > SUM_MAX) r = WORD_MAX;
    else if (v < SUM_MIN) r = WORD_MIN;
    else r = v[WORD_BITS-1:0];
    return r;
  endfunction

  function automatic logic signed [WORD_BITS-1:0] sat_abs(
    input logic signed [WORD_BITS-1:0] v
  );
    logic signed [WORD_BITS-1:0] r;
    if (v == WORD_MIN) r = WORD_MAX;
    else if (v < 0) r = -v;
    else r = v;
    return r;
  endfunction

  logic [PIX_BITS-1:0]          col_q;
  logic [PIX_BITS-1:0]          row_q;
  logic signed [PROD_BITS-1:0]  prod_re;
  logic signed [PROD_BITS-1:0]  prod_im;
  logic signed [WORD_BITS-1:0]  c_re;
  logic signed [WORD_BITS-1:0]  c_im;
  logic signed [WORD_BITS-1:0]  z_re;
  logic signed [WORD_BITS-1:0]  z_im;
  logic signed [SQ_BITS-1:0]    sq_re;
  logic signed [SQ_BITS-1:0]    sq_im;
  logic signed [SQ_BITS-1:0]    xp;
  logic                         fix_re;
  logic                         fix_im;
  logic [ITER_BITS-1:0]         n;

  logic                         ship;
  logic                         julia;
  logic signed [WORD_BITS-1:0]  p_re;
  logic signed [WORD_BITS-1:0]  p_im;
  logic signed [WORD_BITS-1:0]  a_re;
  logic signed [WORD_BITS-1:0]  a_im;
  logic signed [SQ_BITS-1:0]    d;
  logic signed [SQ_BITS-1:0]    d_sh;
  logic signed [SQ_BITS-1:0]    x_sh;
  logic signed [WORD_BITS-1:0]  re_next;
  logic signed [WORD_BITS-1:0]  im_next;
  logic [SQ_BITS-1:0]           mag;
  logic [ITER_BITS:0]           n_inc;

  always_comb begin
    ship  = (cfg.mode == MODE_SHIP);
    julia = (cfg.mode == MODE_JULIA);
    p_re  = sat_word(SUM_BITS'($signed(cfg.x_origin)) + SUM_BITS'(prod_re));
    p_im  = sat_word(SUM_BITS'($signed(cfg.y_origin)) + SUM_BITS'(prod_im));
    a_re  = ship ? sat_abs(z_re) : z_re;
    a_im  = ship ? sat_abs(z_im) : z_im;
    d     = sq_re - sq_im;
    // floor shifts; the cross term carries the factor two
    d_sh  = d >>> FRAC_BITS;
    x_sh  = xp >>> (FRAC_BITS - 1);
    re_next = sat_word(SUM_BITS'(d_sh) + SUM_BITS'(c_re));
    im_next = sat_word(SUM_BITS'(x_sh) + SUM_BITS'(c_im));
    mag   = $unsigned(sq_re) + $unsigned(sq_im)
          + (fix_re ? MIN_FIX : '0) + (fix_im ? MIN_FIX : '0);
    n_inc = (ITER_BITS+1)'(n) + (ITER_BITS+1)'(1);

    stat.julia       = julia;
    stat.mag_below   = !MAG_REACH || (mag < MAG_LIMIT);
    stat.mag_above   = MAG_REACH && (mag > MAG_LIMIT);
    stat.at_max      = (n >= cfg.max_iter);
    stat.next_at_max = (n_inc >= (ITER_BITS+1)'(cfg.max_iter));
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_q <= PIX_BITS'(pixel_col[PIX_USE-1:0]);
      row_q <= PIX_BITS'(pixel_row[PIX_USE-1:0]);
    end
    if (cmd.map) begin
      prod_re <= $signed({1'b0, col_q}) * $signed(cfg.x_step);
      prod_im <= $signed({1'b0, row_q}) * $signed(cfg.y_step);
    end
    if (cmd.load) begin
      n <= '0;
      if (julia) begin
        z_re <= p_re;
        z_im <= p_im;
        c_re <= $signed(cfg.jc_re);
        c_im <= $signed(cfg.jc_im);
      end else begin
        z_re <= '0;
        z_im <= '0;
        c_re <= p_re;
        c_im <= p_im;
      end
    end
    if (cmd.square) begin
      sq_re  <= a_re * a_re;
      sq_im  <= a_im * a_im;
      xp     <= a_re * a_im;
      fix_re <= ship && (z_re == WORD_MIN);
      fix_im <= ship && (z_im == WORD_MIN);
    end
    if (cmd.advance) begin
      z_re <= re_next;
      z_im <= im_next;
    end
    if (cmd.count) begin
      n <= n_inc[ITER_BITS-1:0];
    end
  end

  assign iter_count = n;
  assign out_col    = col_q;
  assign out_row    = row_q;

endmodule

FILE: rtl/core/fete_ctrl.sv
// ----------------------------------------------------------------------------
// fete_ctrl
// Controller: sequences mapping, square and step cycles and the exit tests.
// ----------------------------------------------------------------------------
module fete_ctrl import fete_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  done
);

  state_t state, state_next;
  logic   first, first_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      first <= 1'b0;
    end else begin
      state <= state_next;
      first <= first_next;
    end
  end

  always_comb begin
    state_next = state;
    first_next = first;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd.map    = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        first_next = 1'b1;
        state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_STEP;
      end
      ST_STEP: begin
        if (stat.julia) begin
          // julia tests the magnitude after each step, none before the first
          if (first) begin
            if (stat.at_max) begin
              state_next = ST_DONE;
            end else begin
              cmd.advance = 1'b1;
              first_next  = 1'b0;
              state_next  = ST_SQUARE;
            end
          end else if (stat.mag_above) begin
            state_next = ST_DONE;
          end else if (stat.next_at_max) begin
            cmd.count  = 1'b1;
            state_next = ST_DONE;
          end else begin
            cmd.advance = 1'b1;
            cmd.count   = 1'b1;
            state_next  = ST_SQUARE;
          end
        end else begin
          if (!stat.mag_below || stat.at_max) begin
            state_next = ST_DONE;
          end else begin
            cmd.advance = 1'b1;
            cmd.count   = 1'b1;
            state_next  = ST_SQUARE;
          end
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

endmodule

FILE: rtl/core/fractal_escape_time_engine_core.sv
// ----------------------------------------------------------------------------
// fractal_escape_time_engine_core
// Escape-time engine for Mandelbrot, Burning Ship and Julia sets in Q4.28.
// ----------------------------------------------------------------------------
// A pixel is taken when start is high and busy is low; busy then stays high
// until its result has been shown. Each escape iteration has a square step
// for the three registered 32x32 products and a step for the add, saturate
// and magnitude test. The result is on iter_count, out_col and out_row
// for exactly one cycle with done high and cannot be held off; it must be
// captured then. Configuration is written through wr_en, wr_index and
// wr_data; the user must write it only while busy is low, as the block
// itself does not enforce this.
module fractal_escape_time_engine_core import fete_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [PIX_BITS-1:0]     pixel_col,
  input  logic [PIX_BITS-1:0]     pixel_row,
  output logic                    done,
  output logic [ITER_BITS-1:0]    iter_count,
  output logic [PIX_BITS-1:0]     out_col,
  output logic [PIX_BITS-1:0]     out_row,
  input  logic                    wr_en,
  input  logic [REG_IDX_BITS-1:0] wr_index,
  input  logic [WORD_BITS-1:0]    wr_data
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  fete_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  fete_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  fete_dp u_dp (
    .clk        (clk),
    .cfg        (cfg),
    .cmd        (cmd),
    .pixel_col  (pixel_col),
    .pixel_row  (pixel_row),
    .stat       (stat),
    .iter_count (iter_count),
    .out_col    (out_col),
    .out_row    (out_row)
  );

  // a pixel is only started by an accepted item
  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted item");

  // a result is shown only while the pixel is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result shown while idle");

  // one result per item: the engine is free right after the result
  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |=> (!busy && !done))
    else $error("engine not released after result");

  // the datapath never captures in the same cycle as it squares, advances or counts
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> !(cmd.square || cmd.advance || cmd.count))
    else $error("conflicting datapath commands");

endmodule
